// File: rtl/core/palt_pkg.sv
// ----------------------------------------------------------------------------
// palt_pkg
// Shared types and constants of the palindromic tree builder.
// ----------------------------------------------------------------------------
package palt_pkg;

  localparam int unsigned FIELD_W  = 13;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_W_START = 10'b00_0000_0010,
    ST_W_NODE  = 10'b00_0000_0100,
    ST_W_HIST  = 10'b00_0000_1000,
    ST_C_RD    = 10'b00_0001_0000,
    ST_C_VAL   = 10'b00_0010_0000,
    ST_L_RD    = 10'b00_0100_0000,
    ST_L_NODE  = 10'b00_1000_0000,
    ST_WRITE   = 10'b01_0000_0000,
    ST_DONE    = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic               overflow;
    logic               created_node;
    logic [FIELD_W-1:0] distinct_palindromes;
    logic [FIELD_W-1:0] suffix_palindromes;
    logic [FIELD_W-1:0] longest_suffix_len;
  } result_t;

endpackage

// File: rtl/core/palt_ram.sv
// ----------------------------------------------------------------------------
// palt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module palt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/core/palindromic_tree_builder_unit.sv
// ----------------------------------------------------------------------------
// palindromic_tree_builder_unit
// Builds a palindromic tree over a stream of letters, one letter a transfer.
// ----------------------------------------------------------------------------
// Each letter walks the suffix links; each link visited costs a node read, a
// history read and the compare, the even root only the history read and the
// odd root neither. The accept, the child lookup and the result follow.
// A letter that creates a node walks a second suffix chain for the new link.
// The walk through the node and history memories sets the rate, and the
// result waits while the output is stalled. A rejected letter goes straight
// to the result.
module palindromic_tree_builder_unit #(
  parameter int unsigned MAX_CHARS = 4096,
  parameter int unsigned ALPHABET  = 26
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  logic        s_axis_tuser,   // [0] new_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [12:0] longest_suffix_len,
                                      // [25:13] suffix_palindromes,
                                      // [38:26] distinct_palindromes, [39] zero
  output logic [1:0]  m_axis_tuser    // [0] created_node, [1] overflow
);

  localparam int unsigned NodeCap = MAX_CHARS + 2;
  localparam int unsigned NW      = $clog2(NodeCap);
  localparam int unsigned HistD   = MAX_CHARS + 1;
  localparam int unsigned HW      = $clog2(HistD);
  localparam int unsigned LW      = NW + 2;
  localparam int unsigned ChildD  = NodeCap * ALPHABET;
  localparam int unsigned CW      = $clog2(ChildD);
  localparam int unsigned LtW     = palt_pkg::LETTER_W;
  localparam int unsigned NodeW   = 4 * NW + 1 + LtW;

  palt_pkg::state_e state_q, state_d;

  logic [NW-1:0]          last_q, last_d, total_q, total_d;
  logic [HW-1:0]          taken_q, taken_d;
  logic [LtW-1:0]         ch_q, ch_d;
  logic [NW-1:0]          v_q, v_d, link_q, link_d;
  logic signed [LW-1:0]   len_q, len_d, lenu_q, lenu_d;
  logic [NW-1:0]          u_q, u_d, linku_q, linku_d, c_q, c_d, lk_q, lk_d;
  logic [NW-1:0]          dlk_q, dlk_d;
  logic                   phase2_q, phase2_d;
  logic [NW-1:0]          res_len_q, res_len_d, res_dep_q, res_dep_d;
  logic                   res_new_q, res_new_d, res_ovf_q, res_ovf_d;
  logic                   out_valid_q, out_valid_d;
  palt_pkg::result_t      out_q, out_d;

  logic             hist_we, hist_re;
  logic [HW-1:0]    hist_waddr, hist_raddr;
  logic [LtW-1:0]   hist_rdata;
  logic             node_we, node_re;
  logic [NW-1:0]    node_waddr, node_raddr;
  logic [NodeW-1:0] node_wdata, node_rdata;
  logic             child_we, child_re;
  logic [CW-1:0]    child_waddr, child_raddr;
  logic [NW-1:0]    child_rdata;

  logic [NW-1:0]        rd_link, rd_dep, rd_par;
  logic signed [LW-1:0] rd_len;
  logic [LtW-1:0]       rd_let;

  logic                 walk_hit;
  logic signed [LW-1:0] walk_len, pos;
  logic [NW-1:0]        walk_link, eff_last, eff_total;
  logic [HW-1:0]        eff_taken;
  logic                 go_create, bad_letter;
  logic [LtW-1:0]       in_letter;
  logic [NW-1:0]        new_len, new_dep;

  assign rd_link = node_rdata[NW-1:0];
  assign rd_len  = LW'($signed(node_rdata[2*NW:NW]));
  assign rd_dep  = node_rdata[3*NW:2*NW+1];
  assign rd_par  = node_rdata[4*NW:3*NW+1];
  assign rd_let  = node_rdata[NodeW-1:4*NW+1];

  assign in_letter  = s_axis_tdata[LtW-1:0];
  assign bad_letter = (32'(in_letter) >= ALPHABET);
  assign eff_last   = s_axis_tuser ? '0 : last_q;
  assign eff_total  = s_axis_tuser ? NW'(2) : total_q;
  assign eff_taken  = s_axis_tuser ? '0 : taken_q;
  assign new_len    = NW'(lenu_q + LW'(2));
  assign new_dep    = dlk_q + NW'(1);

  assign s_axis_tready = (state_q == palt_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.distinct_palindromes, out_q.suffix_palindromes,
                          out_q.longest_suffix_len};
  assign m_axis_tuser  = {out_q.overflow, out_q.created_node};

  always_comb begin
    state_d = state_q;
    last_d = last_q; total_d = total_q; taken_d = taken_q; ch_d = ch_q;
    v_d = v_q; link_d = link_q; len_d = len_q; lenu_d = lenu_q;
    u_d = u_q; linku_d = linku_q; c_d = c_q; lk_d = lk_q; dlk_d = dlk_q;
    phase2_d = phase2_q;
    res_len_d = res_len_q; res_dep_d = res_dep_q;
    res_new_d = res_new_q; res_ovf_d = res_ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d = out_q;
    hist_we = 1'b0; hist_waddr = '0; hist_re = 1'b0; hist_raddr = '0;
    node_we = 1'b0; node_waddr = '0; node_wdata = '0;
    node_re = 1'b0; node_raddr = '0;
    child_we = 1'b0; child_waddr = '0; child_re = 1'b0; child_raddr = '0;
    walk_hit = 1'b0; walk_len = '0; walk_link = '0; go_create = 1'b0;
    pos = LW'(taken_q) - rd_len - LW'(1);

    unique case (state_q)
      palt_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          last_d  = eff_last;
          total_d = eff_total;
          taken_d = eff_taken;
          if (bad_letter || (eff_taken == HW'(MAX_CHARS))) begin
            res_len_d = '0; res_dep_d = '0; res_new_d = 1'b0; res_ovf_d = 1'b1;
            state_d = palt_pkg::ST_DONE;
          end else begin
            taken_d    = eff_taken + HW'(1);
            hist_we    = 1'b1;
            hist_waddr = eff_taken + HW'(1);
            ch_d       = in_letter;
            v_d        = eff_last;
            phase2_d   = 1'b0;
            state_d    = palt_pkg::ST_W_START;
          end
        end
      end
      palt_pkg::ST_W_START: begin
        if (v_q == NW'(1)) begin
          walk_hit = 1'b1; walk_len = -LW'(1); walk_link = NW'(1);
        end else if (v_q == '0) begin
          len_d = '0; link_d = NW'(1);
          if (taken_q >= HW'(2)) begin
            hist_re = 1'b1; hist_raddr = taken_q - HW'(1);
            state_d = palt_pkg::ST_W_HIST;
          end else begin
            v_d = NW'(1);
          end
        end else begin
          node_re = 1'b1; node_raddr = v_q;
          state_d = palt_pkg::ST_W_NODE;
        end
      end
      palt_pkg::ST_W_NODE: begin
        len_d = rd_len; link_d = rd_link;
        if (pos >= LW'(1)) begin
          hist_re = 1'b1; hist_raddr = HW'(pos);
          state_d = palt_pkg::ST_W_HIST;
        end else begin
          v_d = rd_link;
          state_d = palt_pkg::ST_W_START;
        end
      end
      palt_pkg::ST_W_HIST: begin
        if (hist_rdata == ch_q) begin
          walk_hit = 1'b1; walk_len = len_q; walk_link = link_q;
        end else begin
          v_d = link_q;
          state_d = palt_pkg::ST_W_START;
        end
      end
      palt_pkg::ST_C_RD: begin
        if (child_rdata >= NW'(2) && child_rdata < total_q) begin
          c_d = child_rdata;
          node_re = 1'b1; node_raddr = child_rdata;
          state_d = palt_pkg::ST_C_VAL;
        end else begin
          go_create = 1'b1;
        end
      end
      palt_pkg::ST_C_VAL: begin
        if (rd_par == u_q && rd_let == ch_q) begin
          res_len_d = NW'(rd_len); res_dep_d = rd_dep;
          res_new_d = 1'b0; res_ovf_d = 1'b0;
          last_d = c_q;
          state_d = palt_pkg::ST_DONE;
        end else begin
          go_create = 1'b1;
        end
      end
      palt_pkg::ST_L_RD: begin
        lk_d = child_rdata;
        if (child_rdata < NW'(2)) begin
          dlk_d = '0;
          state_d = palt_pkg::ST_WRITE;
        end else begin
          node_re = 1'b1; node_raddr = child_rdata;
          state_d = palt_pkg::ST_L_NODE;
        end
      end
      palt_pkg::ST_L_NODE: begin
        dlk_d = rd_dep;
        state_d = palt_pkg::ST_WRITE;
      end
      palt_pkg::ST_WRITE: begin
        node_we    = 1'b1;
        node_waddr = total_q;
        node_wdata = {ch_q, u_q, new_dep, (NW+1)'(lenu_q + LW'(2)), lk_q};
        child_we   = 1'b1;
        child_waddr = CW'(CW'(u_q) * CW'(ALPHABET) + CW'(ch_q));
        res_len_d = new_len; res_dep_d = new_dep;
        res_new_d = 1'b1; res_ovf_d = 1'b0;
        last_d  = total_q;
        total_d = total_q + NW'(1);
        state_d = palt_pkg::ST_DONE;
      end
      palt_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d.longest_suffix_len   = palt_pkg::FIELD_W'(res_len_q);
          out_d.suffix_palindromes   = palt_pkg::FIELD_W'(res_dep_q);
          out_d.distinct_palindromes = palt_pkg::FIELD_W'(total_q - NW'(2));
          out_d.created_node         = res_new_q;
          out_d.overflow             = res_ovf_q;
          state_d = palt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = palt_pkg::ST_IDLE;
      end
    endcase

    if (walk_hit) begin
      child_re    = 1'b1;
      child_raddr = CW'(CW'(v_q) * CW'(ALPHABET) + CW'(ch_q));
      if (!phase2_q) begin
        u_d = v_q; lenu_d = walk_len; linku_d = walk_link;
        state_d = palt_pkg::ST_C_RD;
      end else begin
        state_d = palt_pkg::ST_L_RD;
      end
    end

    if (go_create) begin
      if (u_q == NW'(1)) begin
        lk_d = '0; dlk_d = '0;
        state_d = palt_pkg::ST_WRITE;
      end else begin
        v_d = linku_q; phase2_d = 1'b1;
        state_d = palt_pkg::ST_W_START;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= palt_pkg::ST_IDLE;
      last_q <= '0; total_q <= NW'(2); taken_q <= '0;
      ch_q <= '0; v_q <= '0; link_q <= '0; len_q <= '0; lenu_q <= '0;
      u_q <= '0; linku_q <= '0; c_q <= '0; lk_q <= '0; dlk_q <= '0;
      phase2_q <= 1'b0;
      res_len_q <= '0; res_dep_q <= '0; res_new_q <= 1'b0; res_ovf_q <= 1'b0;
      out_valid_q <= 1'b0; out_q <= '0;
    end else begin
      state_q <= state_d;
      last_q <= last_d; total_q <= total_d; taken_q <= taken_d;
      ch_q <= ch_d; v_q <= v_d; link_q <= link_d; len_q <= len_d; lenu_q <= lenu_d;
      u_q <= u_d; linku_q <= linku_d; c_q <= c_d; lk_q <= lk_d; dlk_q <= dlk_d;
      phase2_q <= phase2_d;
      res_len_q <= res_len_d; res_dep_q <= res_dep_d;
      res_new_q <= res_new_d; res_ovf_q <= res_ovf_d;
      out_valid_q <= out_valid_d; out_q <= out_d;
    end
  end

  palt_ram #(.WIDTH(LtW), .DEPTH(HistD)) u_hist_ram (
    .clk_i(clk_i), .we_i(hist_we), .waddr_i(hist_waddr), .wdata_i(ch_d),
    .re_i(hist_re), .raddr_i(hist_raddr), .rdata_o(hist_rdata)
  );

  palt_ram #(.WIDTH(NodeW), .DEPTH(NodeCap)) u_node_ram (
    .clk_i(clk_i), .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .re_i(node_re), .raddr_i(node_raddr), .rdata_o(node_rdata)
  );

  palt_ram #(.WIDTH(NW), .DEPTH(ChildD)) u_child_ram (
    .clk_i(clk_i), .we_i(child_we), .waddr_i(child_waddr), .wdata_i(total_q),
    .re_i(child_re), .raddr_i(child_raddr), .rdata_o(child_rdata)
  );

endmodule

// File: rtl/core/palt_checker.sv
// ----------------------------------------------------------------------------
// palt_checker
// Port-level checks of the palindromic tree builder, bound to the top level.
// ----------------------------------------------------------------------------
module palt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("Result changed while stalled.");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[25:0] == 26'd0
      && !m_axis_tuser[0])
    else $error("Rejected letter reported a palindrome.");

  a_count_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[25:13] != 13'd0
      && m_axis_tdata[25:13] <= m_axis_tdata[12:0])
    else $error("Suffix palindrome count inconsistent with length.");

  a_new_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[38:26] != 13'd0)
    else $error("New node without a distinct palindrome.");

endmodule

bind palindromic_tree_builder_unit palt_checker u_palt_checker (.*);
